@@ rtl/mrs_pkg.sv @@
// Shared types, constants and helper functions of the register slave.
package mrs_pkg;

	localparam int unsigned FRAME_LEN   = 8;
	localparam int unsigned REPLY_LEN   = 9;
	localparam int unsigned CRC_SPAN    = 7;

	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] CRC_POLY    = 16'hA001;
	localparam logic [7:0]  FN_WRITE    = 8'h06;
	localparam logic [7:0]  FN_READ     = 8'h03;
	localparam logic [7:0]  TYPE_REG_HI = 8'h00;
	localparam logic [7:0]  TYPE_REG_LO = 8'h10;
	localparam logic [7:0]  BYTE_COUNT  = 8'h04;
	localparam logic [7:0]  SLAVE_ADDR  = 8'h01;
	localparam logic [15:0] TYPE_RESET  = 16'd3;
	localparam logic [15:0] MOIST_RESET = 16'd128;

	localparam logic [3:0]  LAST_ECHO   = 4'(FRAME_LEN - 1);
	localparam logic [3:0]  LAST_CRC    = 4'(CRC_SPAN - 1);
	localparam logic [3:0]  LAST_REPLY  = 4'(REPLY_LEN - 1);
	localparam logic [3:0]  CRC_BITS    = 4'd8;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_ECHO_RD,
		ST_ECHO_PUT,
		ST_RD_FEED,
		ST_RD_WAIT,
		ST_RD_SEND
	} state_t;

	// Request from the sequencer to the CRC unit
	typedef struct packed {
		logic       init;
		logic       feed;
		logic [7:0] data;
	} crc_req_t;

	// One bit step of the reflected CRC-16
	function automatic logic [15:0] crc_step(input logic [15:0] crc);
		logic [15:0] res;
		res = {1'b0, crc[15:1]};
		if (crc[0]) begin
			res = res ^ CRC_POLY;
		end
		return res;
	endfunction

	// Byte of the read reply at a given position
	function automatic logic [7:0] reply_byte(input logic [3:0] idx, input logic [15:0] type_word,
		input logic [15:0] moist, input logic [15:0] crc);
		logic [7:0] res;
		case (idx)
			4'd0:    res = SLAVE_ADDR;
			4'd1:    res = FN_READ;
			4'd2:    res = BYTE_COUNT;
			4'd3:    res = type_word[15:8];
			4'd4:    res = type_word[7:0];
			4'd5:    res = moist[15:8];
			4'd6:    res = moist[7:0];
			4'd7:    res = crc[7:0];
			default: res = crc[15:8];
		endcase
		return res;
	endfunction

endpackage

@@ rtl/mrs_stream_if.sv @@
// Valid/ready channel interfaces for received items and transmitted bytes.
interface mrs_rx_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] rx_byte;

	modport source (output valid, output kind, output rx_byte, input ready);
	modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

interface mrs_tx_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       last;

	modport source (output valid, output tx_byte, output last, input ready);
	modport sink (input valid, input tx_byte, input last, output ready);
endinterface

@@ rtl/modbus_rtu_register_slave.sv @@
// Top level of the register slave: frame collection, decode sequencer and reply output.
//
//  channel | dir | payload                  | handshake
//  rx_ch   | in  | kind, rx_byte            | valid/ready
//  tx_ch   | out | tx_byte, last            | valid/ready
//  cfg     | in  | cfg_wdata (moisture)     | cfg_we, no wait
//
// The eighth byte of a frame starts decode; only the write and read functions get a reply.
// A write echo reads each frame byte through the registered frame RAM read, then loads it for output.
// A read reply feeds the first 7 reply bytes to the CRC unit, each followed by a wait while
// the unit shifts in its eight bits, then sends the 9 reply bytes, one per cycle without stalls.
// No item is taken while a reply is built; a full output register stalls the sequencer.
// Reset clears the sequencer and counters and loads the type word (3), moisture word (128) and CRC (FFFF).
module modbus_rtu_register_slave (
	input  logic     clk,
	input  logic     arst_n,
	mrs_rx_if.sink   rx_ch,
	mrs_tx_if.source tx_ch,
	input  logic     cfg_we,
	input  logic [15:0] cfg_wdata
);

	mrs_pkg::state_t   state_q, state_d;
	mrs_pkg::crc_req_t crc_req;
	logic              crc_busy;
	logic [15:0]       crc_val;

	logic [2:0]  count_q;
	logic [3:0]  idx_q;
	logic [7:0]  func_q, reg_hi_q, reg_lo_q, data_hi_q, data_lo_q;
	logic [15:0] type_q, moist_q;

	logic        out_valid_q, out_last_q;
	logic [7:0]  out_byte_q;

	logic        rx_acc, can_load;
	logic        ram_we, ram_re;
	logic [7:0]  ram_rdata;
	logic        out_load, out_last_d, idx_clr, idx_inc, type_we;
	logic [7:0]  out_byte_d;

	assign rx_acc   = rx_ch.valid && rx_ch.ready;
	assign can_load = !out_valid_q || tx_ch.ready;
	assign ram_we   = rx_acc && !rx_ch.kind;

	// Frame store
	mrs_ram #(
		.WIDTH(8),
		.DEPTH(mrs_pkg::FRAME_LEN)
	) u_frame_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q),
		.wdata(rx_ch.rx_byte),
		.re   (ram_re),
		.raddr(idx_q[2:0]),
		.rdata(ram_rdata)
	);

	// CRC shifter
	mrs_crc_unit u_crc (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (crc_req),
		.busy  (crc_busy),
		.crc   (crc_val)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mrs_pkg::ST_IDLE: begin
				if (ram_we && count_q == 3'(mrs_pkg::FRAME_LEN - 1)) begin
					state_d = mrs_pkg::ST_DECODE;
				end
			end
			mrs_pkg::ST_DECODE: begin
				if (func_q == mrs_pkg::FN_WRITE) begin
					state_d = mrs_pkg::ST_ECHO_RD;
				end else if (func_q == mrs_pkg::FN_READ) begin
					state_d = mrs_pkg::ST_RD_FEED;
				end else begin
					state_d = mrs_pkg::ST_IDLE;
				end
			end
			mrs_pkg::ST_ECHO_RD: state_d = mrs_pkg::ST_ECHO_PUT;
			mrs_pkg::ST_ECHO_PUT: begin
				if (can_load) begin
					state_d = (idx_q == mrs_pkg::LAST_ECHO) ? mrs_pkg::ST_IDLE
						: mrs_pkg::ST_ECHO_RD;
				end
			end
			mrs_pkg::ST_RD_FEED: state_d = mrs_pkg::ST_RD_WAIT;
			mrs_pkg::ST_RD_WAIT: begin
				if (!crc_busy) begin
					state_d = (idx_q == mrs_pkg::LAST_CRC) ? mrs_pkg::ST_RD_SEND
						: mrs_pkg::ST_RD_FEED;
				end
			end
			mrs_pkg::ST_RD_SEND: begin
				if (can_load && idx_q == mrs_pkg::LAST_REPLY) begin
					state_d = mrs_pkg::ST_IDLE;
				end
			end
			default: state_d = mrs_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		ram_re     = 1'b0;
		crc_req    = '0;
		out_load   = 1'b0;
		out_byte_d = ram_rdata;
		out_last_d = 1'b0;
		idx_clr    = 1'b0;
		idx_inc    = 1'b0;
		type_we    = 1'b0;
		unique case (state_q)
			mrs_pkg::ST_IDLE: ;
			mrs_pkg::ST_DECODE: begin
				idx_clr      = 1'b1;
				crc_req.init = (func_q == mrs_pkg::FN_READ);
				type_we      = (func_q == mrs_pkg::FN_WRITE) &&
					(reg_hi_q == mrs_pkg::TYPE_REG_HI) && (reg_lo_q == mrs_pkg::TYPE_REG_LO);
			end
			mrs_pkg::ST_ECHO_RD: ram_re = 1'b1;
			mrs_pkg::ST_ECHO_PUT: begin
				out_load   = can_load;
				out_last_d = (idx_q == mrs_pkg::LAST_ECHO);
				idx_inc    = can_load;
			end
			mrs_pkg::ST_RD_FEED: begin
				crc_req.feed = 1'b1;
				crc_req.data = mrs_pkg::reply_byte(idx_q, type_q, moist_q, crc_val);
			end
			mrs_pkg::ST_RD_WAIT: begin
				if (!crc_busy) begin
					idx_clr = (idx_q == mrs_pkg::LAST_CRC);
					idx_inc = (idx_q != mrs_pkg::LAST_CRC);
				end
			end
			mrs_pkg::ST_RD_SEND: begin
				out_load   = can_load;
				out_byte_d = mrs_pkg::reply_byte(idx_q, type_q, moist_q, crc_val);
				out_last_d = (idx_q == mrs_pkg::LAST_REPLY);
				idx_clr    = can_load && (idx_q == mrs_pkg::LAST_REPLY);
				idx_inc    = can_load;
			end
			default: ;
		endcase
	end

	// State, frame count and byte index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mrs_pkg::ST_IDLE;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (rx_acc) begin
				count_q <= rx_ch.kind ? 3'd0 : count_q + 3'd1;
			end
			if (idx_clr) begin
				idx_q <= '0;
			end else if (idx_inc) begin
				idx_q <= idx_q + 4'd1;
			end
		end
	end

	// Capture the header fields as they arrive
	always_ff @(posedge clk) begin
		if (ram_we) begin
			case (count_q)
				3'd1:    func_q    <= rx_ch.rx_byte;
				3'd2:    reg_hi_q  <= rx_ch.rx_byte;
				3'd3:    reg_lo_q  <= rx_ch.rx_byte;
				3'd4:    data_hi_q <= rx_ch.rx_byte;
				3'd5:    data_lo_q <= rx_ch.rx_byte;
				default: ;
			endcase
		end
	end

	// Type and moisture registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_q  <= mrs_pkg::TYPE_RESET;
			moist_q <= mrs_pkg::MOIST_RESET;
		end else begin
			if (type_we) begin
				type_q <= {data_hi_q, data_lo_q};
			end
			if (cfg_we) begin
				moist_q <= cfg_wdata;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (tx_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_byte_q <= out_byte_d;
			out_last_q <= out_last_d;
		end
	end

	assign rx_ch.ready   = (state_q == mrs_pkg::ST_IDLE);
	assign tx_ch.valid   = out_valid_q;
	assign tx_ch.tx_byte = out_byte_q;
	assign tx_ch.last    = out_last_q;

	// Partial frames exist only while collecting
	a_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != mrs_pkg::ST_IDLE |-> count_q == 3'd0)
		else $error("frame count nonzero outside idle");

	// CRC unit is quiet whenever a byte is fed or the reply is sent
	a_crc_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mrs_pkg::ST_RD_FEED || state_q == mrs_pkg::ST_RD_SEND) |-> !crc_busy)
		else $error("CRC unit busy at feed or send");

	// Never overwrite an untaken result
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> can_load)
		else $error("output register overwritten");

	// Index stays within the reply
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= mrs_pkg::LAST_REPLY)
		else $error("byte index out of range");

endmodule

@@ rtl/mrs_ram.sv @@
// Generic single-port-write, registered-read RAM.
module mrs_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, held while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/mrs_crc_unit.sv @@
// Bit-serial CRC-16 unit: one shift step per cycle, eight per fed byte.
module mrs_crc_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  mrs_pkg::crc_req_t req,
	output logic              busy,
	output logic [15:0]       crc
);

	logic [15:0] crc_q;
	logic [3:0]  cnt_q;

	// Load, fold in a byte, or shift one bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= mrs_pkg::CRC_INIT;
			cnt_q <= '0;
		end else if (req.init) begin
			crc_q <= mrs_pkg::CRC_INIT;
			cnt_q <= '0;
		end else if (req.feed) begin
			crc_q <= crc_q ^ {8'h00, req.data};
			cnt_q <= mrs_pkg::CRC_BITS;
		end else if (cnt_q != '0) begin
			crc_q <= mrs_pkg::crc_step(crc_q);
			cnt_q <= cnt_q - 4'd1;
		end
	end

	assign busy = (cnt_q != '0);
	assign crc  = crc_q;

endmodule
